/* rtl/wrtd_pkg.sv */
// shared types, constants and the arctangent table of the waypoint controller
// no dependencies
package wrtd_pkg;

  localparam int GOAL_DEPTH   = 16;
  localparam int CORDIC_STEPS = 14;
  localparam int ATAN_LEN     = 20;

  localparam int GIDX_W     = $clog2(GOAL_DEPTH);
  localparam int GCNT_W     = $clog2(GOAL_DEPTH + 1);
  localparam int STEP_W     = $clog2(CORDIC_STEPS + 1);
  localparam int ATAN_IDX_W = $clog2(ATAN_LEN);

  localparam int DELTA_W  = 18;
  localparam int CORDIC_W = 27;
  localparam int ANGLE_W  = 17;
  localparam int PROD_W   = 2 * DELTA_W;
  localparam int DIST_W   = 34;

  localparam logic signed [ANGLE_W-1:0] PI_Q12 = 17'sd12868;

  localparam logic [1:0] CMD_POSE    = 2'd0;
  localparam logic [1:0] CMD_ENQUEUE = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  localparam logic [1:0] ACT_STOP    = 2'd0;
  localparam logic [1:0] ACT_ROTATE  = 2'd1;
  localparam logic [1:0] ACT_DRIVE   = 2'd2;
  localparam logic [1:0] ACT_REACHED = 2'd3;

  localparam logic [1:0] REG_LINEAR_SPEED  = 2'd0;
  localparam logic [1:0] REG_ANGULAR_SPEED = 2'd1;
  localparam logic [1:0] REG_DIST_THRESH   = 2'd2;
  localparam logic [1:0] REG_ANGLE_THRESH  = 2'd3;

  typedef struct packed {
    logic signed [7:0] gx;
    logic signed [7:0] gy;
    logic [7:0]        id;
  } goal_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

  // atan(2^-i) in q4.12
  function automatic logic signed [ANGLE_W-1:0] atan_q12(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [ANGLE_W-1:0] r;
    case (idx)
      5'd0:    r = 17'sd3217;
      5'd1:    r = 17'sd1899;
      5'd2:    r = 17'sd1003;
      5'd3:    r = 17'sd509;
      5'd4:    r = 17'sd256;
      5'd5:    r = 17'sd128;
      5'd6:    r = 17'sd64;
      5'd7:    r = 17'sd32;
      5'd8:    r = 17'sd16;
      5'd9:    r = 17'sd8;
      5'd10:   r = 17'sd4;
      5'd11:   r = 17'sd2;
      5'd12:   r = 17'sd1;
      default: r = 17'sd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/waypoint_rotate_then_drive_controller.sv */
// Waypoint controller top: keeps the pose and a queue of goals and answers each control tick
// with stop, rotate, drive or goal reached. Depends on wrtd_pkg, wrtd_goal_fifo, wrtd_cordic.
// Pose and enqueue items give no result and leave the unit idle. A tick on an empty queue
// goes straight to the finish state, which registers its result. A tick with a goal passes
// through load and start to the iterative cordic bearing unit and then to a decide step that
// gives rotate, or else goes on through three passes of the one shared 18x18 multiplier for
// the squared distances and a compare that give drive or goal reached; a goal that sits right
// on the pose skips the cordic steps. in_ready is low while a tick is worked on, and the next
// item is taken at the earliest in the cycle after the result is registered; a finished
// result sits in the output register until taken, and a later tick that finishes before
// then waits for it. Registers sit at byte addresses 0, 4, 8 and 12 of the apb-style port.
module waypoint_rotate_then_drive_controller import wrtd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [14:0] heading,
  input  logic [7:0]         goal_id,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         action,
  output logic [14:0]        linear_cmd,
  output logic signed [15:0] angular_cmd,
  output logic [7:0]         removed_id,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOAD   = 4'd1;
  localparam logic [3:0] S_START  = 4'd2;
  localparam logic [3:0] S_WAIT   = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_SQX    = 4'd5;
  localparam logic [3:0] S_SQY    = 4'd6;
  localparam logic [3:0] S_SQT    = 4'd7;
  localparam logic [3:0] S_CMP    = 4'd8;
  localparam logic [3:0] S_FINISH = 4'd9;

  logic [3:0] state;

  logic [14:0] linear_speed;
  logic [14:0] angular_speed;
  logic [14:0] distance_threshold;
  logic [14:0] angle_threshold;

  logic signed [15:0] robot_x;
  logic signed [15:0] robot_y;
  logic signed [14:0] robot_heading;

  goal_t        push_goal;
  goal_t        head_goal;
  fifo_status_t fifo_status;
  logic         push;
  logic         pop;
  logic         in_accept;

  logic signed [DELTA_W-1:0] dx;
  logic signed [DELTA_W-1:0] dy;
  logic signed [15:0]        goal_xf;
  logic signed [15:0]        goal_yf;
  logic                      cordic_done;
  logic signed [ANGLE_W-1:0] cordic_angle;
  logic signed [ANGLE_W-1:0] bearing;
  logic signed [DELTA_W-1:0] err;
  logic [DELTA_W-1:0]        err_mag;

  logic signed [DELTA_W-1:0] mul_a;
  logic signed [DELTA_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [DIST_W-1:0]         d2;

  logic [1:0]         res_action;
  logic [14:0]        res_linear;
  logic signed [15:0] res_angular;
  logic [7:0]         res_id;

  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign pready    = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_LINEAR_SPEED:  prdata = 32'(linear_speed);
      REG_ANGULAR_SPEED: prdata = 32'(angular_speed);
      REG_DIST_THRESH:   prdata = 32'(distance_threshold);
      REG_ANGLE_THRESH:  prdata = 32'(angle_threshold);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      linear_speed       <= 15'd128;
      angular_speed      <= 15'd128;
      distance_threshold <= 15'd256;
      angle_threshold    <= 15'd1229;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_LINEAR_SPEED:  linear_speed       <= pwdata[14:0];
        REG_ANGULAR_SPEED: angular_speed      <= pwdata[14:0];
        REG_DIST_THRESH:   distance_threshold <= pwdata[14:0];
        REG_ANGLE_THRESH:  angle_threshold    <= pwdata[14:0];
        default:           linear_speed       <= linear_speed;
      endcase
    end
  end

  // truncate toward zero to a whole unit
  assign push_goal.gx = pos_x[15:8] + 8'(pos_x[15] && (pos_x[7:0] != 8'h00));
  assign push_goal.gy = pos_y[15:8] + 8'(pos_y[15] && (pos_y[7:0] != 8'h00));
  assign push_goal.id = goal_id;
  assign push = in_accept && (command == CMD_ENQUEUE);
  assign pop  = (state == S_CMP) && !(d2 > DIST_W'(prod));

  wrtd_goal_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_goal (push_goal),
    .pop       (pop),
    .head_goal (head_goal),
    .status    (fifo_status)
  );

  wrtd_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_START),
    .dx    (dx),
    .dy    (dy),
    .done  (cordic_done),
    .angle (cordic_angle)
  );

  assign goal_xf = {head_goal.gx, 8'h00};
  assign goal_yf = {head_goal.gy, 8'h00};
  assign err     = DELTA_W'(bearing) - DELTA_W'(robot_heading);
  assign err_mag = err[DELTA_W-1] ? DELTA_W'(-err) : DELTA_W'(err);

  // shared multiplier operand select
  always_comb begin
    case (state)
      S_SQX: begin
        mul_a = dx;
        mul_b = dx;
      end
      S_SQY: begin
        mul_a = dy;
        mul_b = dy;
      end
      default: begin
        mul_a = $signed({3'b000, distance_threshold});
        mul_b = $signed({3'b000, distance_threshold});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      robot_x       <= '0;
      robot_y       <= '0;
      robot_heading <= '0;
    end else begin
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            case (command)
              CMD_POSE: begin
                robot_x       <= pos_x;
                robot_y       <= pos_y;
                robot_heading <= heading;
              end
              CMD_TICK: begin
                res_action  <= ACT_STOP;
                res_linear  <= '0;
                res_angular <= '0;
                res_id      <= '0;
                state       <= fifo_status.empty ? S_FINISH : S_LOAD;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_LOAD: begin
          dx    <= DELTA_W'(goal_xf) - DELTA_W'(robot_x);
          dy    <= DELTA_W'(goal_yf) - DELTA_W'(robot_y);
          state <= S_START;
        end
        S_START: state <= S_WAIT;
        S_WAIT: begin
          if (cordic_done) begin
            bearing <= cordic_angle;
            state   <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (err_mag > DELTA_W'(angle_threshold)) begin
            res_action  <= ACT_ROTATE;
            res_angular <= (bearing < robot_heading) ? -$signed({1'b0, angular_speed})
                                                     : $signed({1'b0, angular_speed});
            state       <= S_FINISH;
          end else begin
            state <= S_SQX;
          end
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          d2    <= DIST_W'(prod);
          state <= S_SQT;
        end
        S_SQT: begin
          d2    <= d2 + DIST_W'(prod);
          state <= S_CMP;
        end
        S_CMP: begin
          if (d2 > DIST_W'(prod)) begin
            res_action <= ACT_DRIVE;
            res_linear <= linear_speed;
          end else begin
            res_action <= ACT_REACHED;
            res_id     <= head_goal.id;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            action      <= res_action;
            linear_cmd  <= res_linear;
            angular_cmd <= res_angular;
            removed_id  <= res_id;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/wrtd_goal_fifo.sv */
// circular goal queue: storage array, head pointer and fill count
// depends on wrtd_pkg
module wrtd_goal_fifo import wrtd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  goal_t        push_goal,
  input  logic         pop,
  output goal_t        head_goal,
  output fifo_status_t status
);

  goal_t             mem [GOAL_DEPTH];
  logic [GIDX_W-1:0] head;
  logic [GCNT_W-1:0] count;
  logic [GIDX_W:0]   tail_sum;
  logic [GIDX_W:0]   tail_wrap;
  logic [GIDX_W-1:0] tail;
  logic              push_ok;
  logic              pop_ok;

  assign status.empty = (count == '0);
  assign status.full  = (count == GCNT_W'(GOAL_DEPTH));

  assign push_ok = push && !status.full;
  assign pop_ok  = pop && !status.empty;

  assign tail_sum  = {1'b0, head} + (GIDX_W+1)'(count);
  assign tail_wrap = (tail_sum >= (GIDX_W+1)'(GOAL_DEPTH)) ?
                     tail_sum - (GIDX_W+1)'(GOAL_DEPTH) : tail_sum;
  assign tail      = tail_wrap[GIDX_W-1:0];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[tail] <= push_goal;
    end
    head_goal <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (pop_ok) begin
        head <= (head == GIDX_W'(GOAL_DEPTH - 1)) ? '0 : head + 1'b1;
      end
      case ({push_ok, pop_ok})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/wrtd_cordic.sv */
// iterative cordic vectoring unit giving the bearing of (dx, dy) in q4.12
// depends on wrtd_pkg
module wrtd_cordic import wrtd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [DELTA_W-1:0] dx,
  input  logic signed [DELTA_W-1:0] dy,
  output logic                      done,
  output logic signed [ANGLE_W-1:0] angle
);

  logic signed [CORDIC_W-1:0] x;
  logic signed [CORDIC_W-1:0] y;
  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;
  logic signed [CORDIC_W-1:0] x0;
  logic signed [CORDIC_W-1:0] y0;
  logic signed [ANGLE_W-1:0]  step_atan;
  logic [STEP_W-1:0]          step;
  logic                       busy;

  assign x0 = CORDIC_W'(dx) <<< 6;
  assign y0 = CORDIC_W'(dy) <<< 6;
  assign xs = x >>> step;
  assign ys = y >>> step;
  assign step_atan = atan_q12(ATAN_IDX_W'(step));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      if (start) begin
        step <= '0;
        done <= (dx == '0 && dy == '0);
        if (dx == '0 && dy == '0) begin
          angle <= '0;
        end else begin
          busy <= 1'b1;
          if (dx < 0) begin
            x     <= -x0;
            y     <= -y0;
            angle <= (dy >= 0) ? PI_Q12 : -PI_Q12;
          end else begin
            x     <= x0;
            y     <= y0;
            angle <= '0;
          end
        end
      end else if (busy) begin
        if (y >= 0) begin
          x     <= x + ys;
          y     <= y - xs;
          angle <= angle + step_atan;
        end else begin
          x     <= x - ys;
          y     <= y + xs;
          angle <= angle - step_atan;
        end
        done <= (step == STEP_W'(CORDIC_STEPS - 1));
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
        end else begin
          step <= step + 1'b1;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule
